// ===== sv/assert_macros.svh =====
// Assertion macros used by the top-level RTL file of the window peak block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define AWP_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked on every rising edge out of reset.
`define AWP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ===== sv/awp_pkg.sv =====
// Package with the types and constants of the window peak block.
`timescale 1ns / 1ps

package awp_pkg;

    localparam int AXIS_W            = 16;
    localparam int MAG_W             = 16;
    localparam int SUM_W             = 32;
    localparam int HISTORY_DEPTH_DEF = 64;
    localparam logic [MAG_W-1:0] ONE_G = 16'd4096;

    // Request to the square root unit.
    typedef struct packed {
        logic             start;
        logic [SUM_W-1:0] radicand;
    } sqrt_cmd_t;

    // Answer of the square root unit.
    typedef struct packed {
        logic             done;
        logic [MAG_W-1:0] root;
    } sqrt_stat_t;

    // Request to the history ring: store a magnitude and scan for the peak.
    typedef struct packed {
        logic             start;
        logic [MAG_W-1:0] mag;
    } hist_cmd_t;

    // Answer of the history ring.
    typedef struct packed {
        logic             ready;
        logic             done;
        logic [MAG_W-1:0] peak;
    } hist_stat_t;

endpackage

// ===== sv/accel_magnitude_window_peak.sv =====
// Top level: accelerometer magnitude with a sliding-window peak.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Usage:
// One three-axis sample (signed Q3.12, 4096 is one g) enters on the s_ stream
// per transfer. The block returns one result per sample on the m_ stream: the
// floor square root of x*x + y*y + z*z and the window peak, which is the
// largest of the last HISTORY_DEPTH magnitudes, never below peak_floor.
// Each sample passes through the shared squarer for the three axes, sixteen
// iterations of the square root unit, then one memory read per ring entry
// for the peak scan. One sample is processed at a time, so s_tready is low
// until the result sits in the output register; the next sample can be taken
// at once, even if that result has not been taken by the receiver yet.
// After reset the ring is filled with one g, one entry per cycle, which keeps
// s_tready low until the ring is full; peak_floor resets to one g and is
// written through cfg_wen / cfg_wdata. The user must write it only while the
// block is idle; the block itself does not enforce this.
// When the receiver stalls, the result is held on m_tdata and a finished
// second sample waits inside until the output register is free.
module accel_magnitude_window_peak #(
    parameter int HISTORY_DEPTH = awp_pkg::HISTORY_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // accel_x [15:0], accel_y [31:16], accel_z [47:32]
    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // magnitude [15:0], window_peak [31:16]
    // Configuration: peak_floor.
    input  logic        cfg_wen,
    input  logic [15:0] cfg_wdata
);
    import awp_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_ACC,
        S_ROOT,
        S_PEAK,
        S_HOLD
    } state_t;

    state_t                     state_reg;
    logic signed [AXIS_W-1:0]   ax_reg;
    logic signed [AXIS_W-1:0]   ay_reg;
    logic signed [AXIS_W-1:0]   az_reg;
    logic [1:0]                 axis_cnt_reg;
    logic [SUM_W-2:0]           prod_reg;
    logic                       prod_vld_reg;
    logic [SUM_W-1:0]           sum_reg;
    logic [MAG_W-1:0]           mag_reg;
    logic                       sqrt_start_reg;
    logic                       hist_start_reg;
    logic                       m_tvalid_reg;
    logic [31:0]                m_tdata_reg;
    logic [MAG_W-1:0]           peak_floor_reg;

    logic signed [AXIS_W-1:0]   axis_sel;
    logic signed [SUM_W-1:0]    square;
    logic                       out_free;
    logic                       out_load;

    sqrt_cmd_t                  sqrt_cmd;
    sqrt_stat_t                 sqrt_stat;
    hist_cmd_t                  hist_cmd;
    hist_stat_t                 hist_stat;

    // Configuration register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            peak_floor_reg <= ONE_G;
        end else if (cfg_wen) begin
            peak_floor_reg <= cfg_wdata;
        end
    end

    // Shared squarer: one axis per cycle.
    always_comb begin
        unique case (axis_cnt_reg)
            2'd0:    axis_sel = ax_reg;
            2'd1:    axis_sel = ay_reg;
            default: axis_sel = az_reg;
        endcase
    end
    assign square = SUM_W'(axis_sel) * SUM_W'(axis_sel);

    assign out_free = !m_tvalid_reg || m_tready;
    assign out_load = out_free &&
                      ((state_reg == S_PEAK && hist_stat.done) || state_reg == S_HOLD);

    // Sequencer, datapath registers and the output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            axis_cnt_reg   <= '0;
            prod_vld_reg   <= 1'b0;
            sqrt_start_reg <= 1'b0;
            hist_start_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            sqrt_start_reg <= (state_reg == S_ACC);
            hist_start_reg <= (state_reg == S_ROOT) && sqrt_stat.done;
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_tvalid && s_tready) begin
                        ax_reg       <= s_tdata[15:0];
                        ay_reg       <= s_tdata[31:16];
                        az_reg       <= s_tdata[47:32];
                        sum_reg      <= '0;
                        axis_cnt_reg <= '0;
                        prod_vld_reg <= 1'b0;
                        state_reg    <= S_MUL;
                    end
                end
                S_MUL: begin
                    prod_reg     <= square[SUM_W-2:0];
                    prod_vld_reg <= 1'b1;
                    if (prod_vld_reg) begin
                        sum_reg <= sum_reg + {1'b0, prod_reg};
                    end
                    axis_cnt_reg <= axis_cnt_reg + 1'b1;
                    if (axis_cnt_reg == 2'd2) begin
                        state_reg <= S_ACC;
                    end
                end
                S_ACC: begin
                    // Last product joins the sum; the root unit samples it next cycle.
                    sum_reg      <= sum_reg + {1'b0, prod_reg};
                    prod_vld_reg <= 1'b0;
                    state_reg    <= S_ROOT;
                end
                S_ROOT: begin
                    if (sqrt_stat.done) begin
                        mag_reg   <= sqrt_stat.root;
                        state_reg <= S_PEAK;
                    end
                end
                S_PEAK: begin
                    if (hist_stat.done) begin
                        if (out_free) begin
                            m_tdata_reg <= {hist_stat.peak, mag_reg};
                            state_reg   <= S_IDLE;
                        end else begin
                            state_reg <= S_HOLD;
                        end
                    end
                end
                S_HOLD: begin
                    if (out_free) begin
                        m_tdata_reg <= {hist_stat.peak, mag_reg};
                        state_reg   <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign sqrt_cmd.start    = sqrt_start_reg;
    assign sqrt_cmd.radicand = sum_reg;
    assign hist_cmd.start    = hist_start_reg;
    assign hist_cmd.mag      = mag_reg;

    awp_sqrt u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (sqrt_cmd),
        .stat    (sqrt_stat)
    );

    awp_history #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_history (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (hist_cmd),
        .peak_floor (peak_floor_reg),
        .stat       (hist_stat)
    );

    assign s_tready = (state_reg == S_IDLE) && hist_stat.ready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // The block holds off new samples after a transfer until the result is done.
    `AWP_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
    // The root unit only finishes while the sequencer waits for it.
    `AWP_ASSERT_IMPL(a_sqrt_done_in_root, sqrt_stat.done, state_reg == S_ROOT)
    // The peak scan only finishes while the sequencer waits for it.
    `AWP_ASSERT_IMPL(a_hist_done_in_peak, hist_stat.done, state_reg == S_PEAK)
    // The reported peak covers the new magnitude stored in the ring.
    `AWP_ASSERT_IMPL(a_peak_covers_mag, m_tvalid, m_tdata[31:16] >= m_tdata[15:0])

endmodule

// ===== sv/awp_sqrt.sv =====
// Iterative integer square root, two radicand bits per cycle.
`timescale 1ns / 1ps

module awp_sqrt (
    input  logic               aclk,
    input  logic               aresetn,
    input  awp_pkg::sqrt_cmd_t cmd,
    output awp_pkg::sqrt_stat_t stat
);
    import awp_pkg::*;

    localparam int ITER   = SUM_W / 2;
    localparam int ITER_W = $clog2(ITER);

    typedef enum logic {
        Q_IDLE,
        Q_RUN
    } q_state_t;

    q_state_t          state_reg;
    logic [ITER_W-1:0] cnt_reg;
    logic [SUM_W-1:0]  rem_reg;
    logic [SUM_W-1:0]  root_reg;
    logic [SUM_W-1:0]  bit_reg;
    logic              done_reg;
    logic [SUM_W-1:0]  trial;

    // One shared add and compare: the trial subtrahend of this step.
    assign trial = root_reg + bit_reg;

    // Sequencer and the restoring square root step.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= Q_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= (state_reg == Q_RUN) && (cnt_reg == ITER_W'(ITER - 1));
            unique case (state_reg)
                Q_IDLE: begin
                    if (cmd.start) begin
                        rem_reg   <= cmd.radicand;
                        root_reg  <= '0;
                        bit_reg   <= {2'b01, {(SUM_W-2){1'b0}}};
                        cnt_reg   <= '0;
                        state_reg <= Q_RUN;
                    end
                end
                Q_RUN: begin
                    if (rem_reg >= trial) begin
                        rem_reg  <= rem_reg - trial;
                        root_reg <= (root_reg >> 1) + bit_reg;
                    end else begin
                        root_reg <= root_reg >> 1;
                    end
                    bit_reg <= bit_reg >> 2;
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == ITER_W'(ITER - 1)) begin
                        state_reg <= Q_IDLE;
                    end
                end
                default: state_reg <= Q_IDLE;
            endcase
        end
    end

    assign stat.done = done_reg;
    assign stat.root = root_reg[MAG_W-1:0];

endmodule

// ===== sv/awp_history.sv =====
// Ring of recent magnitudes with a clearing pass and a sequential peak scan.
`timescale 1ns / 1ps

module awp_history #(
    parameter int HISTORY_DEPTH = awp_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  awp_pkg::hist_cmd_t          cmd,
    input  logic [awp_pkg::MAG_W-1:0]   peak_floor,
    output awp_pkg::hist_stat_t         stat
);
    import awp_pkg::*;

    localparam int ADDR_W = $clog2(HISTORY_DEPTH);
    localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(HISTORY_DEPTH - 1);

    typedef enum logic [1:0] {
        H_CLEAR,
        H_IDLE,
        H_SCAN,
        H_DRAIN
    } h_state_t;

    h_state_t          state_reg;
    logic [ADDR_W-1:0] idx_reg;
    logic [ADDR_W-1:0] wr_idx_reg;
    logic              rd_vld_reg;
    logic              done_reg;
    logic [MAG_W-1:0]  peak_reg;

    logic [MAG_W-1:0]  mem [HISTORY_DEPTH];
    logic [MAG_W-1:0]  rdata_reg;
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [MAG_W-1:0]  wdata;

    // Write port: one g during the clearing pass, else the new magnitude.
    always_comb begin
        we    = 1'b0;
        waddr = wr_idx_reg;
        wdata = cmd.mag;
        if (state_reg == H_CLEAR) begin
            we    = 1'b1;
            waddr = idx_reg;
            wdata = ONE_G;
        end else if (state_reg == H_IDLE && cmd.start) begin
            we = 1'b1;
        end
    end

    // Memory with one write port and one registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[idx_reg];
    end

    // Sequencer: clearing pass, store, then one read per cycle with a running max.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= H_CLEAR;
            idx_reg    <= '0;
            wr_idx_reg <= '0;
            rd_vld_reg <= 1'b0;
            done_reg   <= 1'b0;
        end else begin
            done_reg   <= (state_reg == H_DRAIN);
            rd_vld_reg <= (state_reg == H_SCAN);
            // The running max starts at the floor and takes each read in turn.
            if (state_reg == H_IDLE && cmd.start) begin
                peak_reg <= peak_floor;
            end else if (rd_vld_reg && rdata_reg > peak_reg) begin
                peak_reg <= rdata_reg;
            end
            unique case (state_reg)
                H_CLEAR: begin
                    if (idx_reg == LAST_IDX) begin
                        idx_reg   <= '0;
                        state_reg <= H_IDLE;
                    end else begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                H_IDLE: begin
                    if (cmd.start) begin
                        wr_idx_reg <= (wr_idx_reg == LAST_IDX) ? '0 : wr_idx_reg + 1'b1;
                        idx_reg    <= '0;
                        state_reg  <= H_SCAN;
                    end
                end
                H_SCAN: begin
                    if (idx_reg == LAST_IDX) begin
                        idx_reg   <= '0;
                        state_reg <= H_DRAIN;
                    end else begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                H_DRAIN: begin
                    // The last read is compared at this edge.
                    state_reg <= H_IDLE;
                end
                default: state_reg <= H_CLEAR;
            endcase
        end
    end

    assign stat.ready = (state_reg == H_IDLE);
    assign stat.done  = done_reg;
    assign stat.peak  = peak_reg;

endmodule
